/* sv/pwli_pkg.sv */
// Package for the piecewise linear interpolator: field widths, item packing,
// register map, request kinds and iteration counts. No dependencies.
package pwli_pkg;

    // Defaults for the top level parameters
    localparam int MAX_POINTS_DEF   = 32;
    localparam int COORD_BITS_DEF   = 32;

    // Field widths
    localparam int REQ_W            = 1;
    localparam int IDX_W            = 5;
    localparam int COORD_W          = 32;
    localparam int POINT_W          = 2 * COORD_W;

    // Input item tdata layout, lowest bit first
    localparam int IDX_LSB          = 0;
    localparam int PX_LSB           = IDX_LSB + IDX_W;
    localparam int PY_LSB           = PX_LSB + COORD_W;
    localparam int EX_LSB           = PY_LSB + COORD_W;
    localparam int HINT_LSB         = EX_LSB + COORD_W;
    localparam int START_LSB        = HINT_LSB + 1;
    localparam int REPORT_LSB       = START_LSB + IDX_W;
    localparam int IN_FIELDS_W      = REPORT_LSB + 1;
    localparam int IN_TDATA_W       = ((IN_FIELDS_W + 7) / 8) * 8;

    // Result item tdata layout, lowest bit first
    localparam int VALUE_LSB        = 0;
    localparam int SPAN_LSB         = VALUE_LSB + COORD_W;
    localparam int OUT_FIELDS_W     = SPAN_LSB + IDX_W;
    localparam int OUT_TDATA_W      = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Request kinds (s_tuser)
    localparam logic [REQ_W-1:0] REQ_LOAD = 1'b0;
    localparam logic [REQ_W-1:0] REQ_EVAL = 1'b1;

    // Configuration port
    localparam int APB_ADDR_W       = 3;
    localparam int APB_DATA_W       = 32;
    localparam int REG_IDX_W        = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_NUM_POINTS = 1'b0;
    localparam int NUM_POINTS_W     = 6;
    localparam logic [NUM_POINTS_W-1:0] NUM_POINTS_RESET = 6'd2;

    // Serial arithmetic: 32-bit magnitudes, 64-bit product
    localparam int MAG_W            = 32;
    localparam int PROD_W           = 2 * MAG_W;
    localparam int ADD_W            = MAG_W + 2;
    localparam int STEP_CNT_W       = 6;
    localparam logic [STEP_CNT_W-1:0] MUL_LAST = 6'd31;
    localparam logic [STEP_CNT_W-1:0] DIV_LAST = 6'd63;

    // One table entry
    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } point_t;

endpackage

/* sv/pwli_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pwli_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/pwl_interpolate.sv */
// Piecewise linear interpolator top level: control point table, span walk,
// serial multiply and divide on one shared adder. Uses pwli_pkg, pwli_ram.
//
//  channel | dir | handshake            | contents
//  --------+-----+----------------------+-----------------------------------------
//  s_      | in  | s_tvalid / s_tready  | tuser: req_type; tdata: load or evaluate
//  m_      | out | m_tvalid / m_tready  | tdata: value, found_span
//  apb     | in  | psel/penable/pready  | num_points at address 0
//
// An evaluate item walks the spans, then runs the 32-step shift-add multiply and
// the 64-step restoring divide on the shared 34-bit adder. s_tready is high only
// while the sequencer is idle; a finished result sits in the output register while
// the next item is taken. Reset clears the sequencer, the output valid and sets
// num_points to 2; the point table is not cleared.
module pwl_interpolate #(
    parameter int MAX_POINTS = pwli_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = pwli_pkg::COORD_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata: point_index, point_x, point_y, eval_x, hint_valid, start_span,
    //        report_span, zero pad
    input  logic [pwli_pkg::IN_TDATA_W-1:0]   s_tdata,
    // tuser: req_type
    input  logic [pwli_pkg::REQ_W-1:0]        s_tuser,
    // result items
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata: value, found_span, zero pad
    output logic [pwli_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pwli_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [pwli_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pwli_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    import pwli_pkg::*;

    localparam int SPAN_W = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int EXT_W  = (CNT_W > NUM_POINTS_W) ? CNT_W : NUM_POINTS_W;
    localparam int QW     = ((COORD_BITS > COORD_W) ? COORD_BITS : COORD_W) + 1;
    localparam int SW     = QW + 2;
    localparam logic signed [SW-1:0] HI_LIM =
        {{(SW - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
    localparam logic signed [SW-1:0] LO_LIM = ~HI_LIM;

    // sequencer states
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_UP_RD  = 4'd1;
    localparam logic [3:0] ST_UP_CMP = 4'd2;
    localparam logic [3:0] ST_DN_RD  = 4'd3;
    localparam logic [3:0] ST_DN_CMP = 4'd4;
    localparam logic [3:0] ST_RD_P0  = 4'd5;
    localparam logic [3:0] ST_RD_P1  = 4'd6;
    localparam logic [3:0] ST_GET_P1 = 4'd7;
    localparam logic [3:0] ST_DX     = 4'd8;
    localparam logic [3:0] ST_DY     = 4'd9;
    localparam logic [3:0] ST_DEN    = 4'd10;
    localparam logic [3:0] ST_SETUP  = 4'd11;
    localparam logic [3:0] ST_MUL    = 4'd12;
    localparam logic [3:0] ST_DIV    = 4'd13;
    localparam logic [3:0] ST_DONE   = 4'd14;

    // input fields
    logic [IDX_W-1:0]          in_idx;
    logic signed [COORD_W-1:0] in_px;
    logic signed [COORD_W-1:0] in_py;
    logic signed [COORD_W-1:0] in_ex;
    logic                      in_hint;
    logic [IDX_W-1:0]          in_start;
    logic                      in_report;

    assign in_idx    = s_tdata[IDX_LSB +: IDX_W];
    assign in_px     = s_tdata[PX_LSB +: COORD_W];
    assign in_py     = s_tdata[PY_LSB +: COORD_W];
    assign in_ex     = s_tdata[EX_LSB +: COORD_W];
    assign in_hint   = s_tdata[HINT_LSB];
    assign in_start  = s_tdata[START_LSB +: IDX_W];
    assign in_report = s_tdata[REPORT_LSB];

    // registers
    logic [3:0]                state_reg, state_next;
    logic [SPAN_W-1:0]         span_reg, span_next;
    logic [SPAN_W-1:0]         last_reg, last_next;
    logic [STEP_CNT_W-1:0]     cnt_reg, cnt_next;
    logic signed [COORD_W-1:0] x_reg, x_next;
    logic [IDX_W-1:0]          start_reg, start_next;
    logic                      rep_reg, rep_next;
    logic                      is_load_reg, is_load_next;
    point_t                    p0_reg, p0_next;
    point_t                    p1_reg, p1_next;
    logic [COORD_W:0]          dx_reg, dx_next;
    logic [COORD_W:0]          dy_reg, dy_next;
    logic [COORD_W:0]          den_reg, den_next;
    logic [MAG_W-1:0]          mcand_reg, mcand_next;
    logic [MAG_W-1:0]          dvsr_reg, dvsr_next;
    logic                      neg_reg, neg_next;
    logic [PROD_W-1:0]         acc_reg, acc_next;
    logic [MAG_W-1:0]          rem_reg, rem_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;
    logic [NUM_POINTS_W-1:0]   num_points_reg, num_points_next;

    // ------------------------------------------------------------------
    // configuration port
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = (reg_idx == REG_NUM_POINTS) ?
                     {{(APB_DATA_W - NUM_POINTS_W){1'b0}}, num_points_reg} : '0;

    always_comb begin
        num_points_next = num_points_reg;
        if (cfg_wr && reg_idx == REG_NUM_POINTS) begin
            num_points_next = pwdata[NUM_POINTS_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // point count clamp and start span
    logic [EXT_W-1:0] np_ext, max_ext, n_cl, last_ext, mid_ext, start_ext, span0_ext;
    logic [EXT_W-1:0] idx_ext, span_ext;

    always_comb begin
        np_ext  = EXT_W'(num_points_reg);
        max_ext = EXT_W'(MAX_POINTS);
        if (np_ext < EXT_W'(2)) begin
            n_cl = EXT_W'(2);
        end else if (np_ext > max_ext) begin
            n_cl = max_ext;
        end else begin
            n_cl = np_ext;
        end
        last_ext  = n_cl - EXT_W'(2);
        mid_ext   = (n_cl >> 1) - EXT_W'(1);
        start_ext = in_hint ? EXT_W'(in_start) : mid_ext;
        span0_ext = (start_ext > last_ext) ? last_ext : start_ext;
        idx_ext   = EXT_W'(in_idx);
        span_ext  = EXT_W'(span_reg);
    end

    // ------------------------------------------------------------------
    // point table
    logic              ram_we;
    logic [SPAN_W-1:0] ram_raddr;
    logic [POINT_W-1:0] ram_rdata;
    point_t            rd_pt;
    point_t            wr_pt;
    logic              s_accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign ram_we   = s_accept && (s_tuser == REQ_LOAD) && (idx_ext < max_ext);
    assign wr_pt    = '{y: in_py, x: in_px};
    assign rd_pt    = point_t'(ram_rdata);

    always_comb begin
        case (state_reg)
            ST_UP_RD, ST_RD_P1: ram_raddr = span_reg + SPAN_W'(1);
            default:            ram_raddr = span_reg;
        endcase
    end

    pwli_ram #(
        .WIDTH (POINT_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_ext[SPAN_W-1:0]),
        .wdata (wr_pt),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // shared adder: compares, differences, multiply and divide steps
    logic [ADD_W-1:0] add_a, add_b, add_sum;
    logic             add_sub;

    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        case (state_reg)
            ST_UP_CMP, ST_DN_CMP: begin
                add_a   = {{2{x_reg[COORD_W-1]}}, x_reg};
                add_b   = {{2{rd_pt.x[COORD_W-1]}}, rd_pt.x};
                add_sub = 1'b1;
            end
            ST_DX: begin
                add_a   = {{2{x_reg[COORD_W-1]}}, x_reg};
                add_b   = {{2{p0_reg.x[COORD_W-1]}}, p0_reg.x};
                add_sub = 1'b1;
            end
            ST_DY: begin
                add_a   = {{2{p1_reg.y[COORD_W-1]}}, p1_reg.y};
                add_b   = {{2{p0_reg.y[COORD_W-1]}}, p0_reg.y};
                add_sub = 1'b1;
            end
            ST_DEN: begin
                add_a   = {{2{p1_reg.x[COORD_W-1]}}, p1_reg.x};
                add_b   = {{2{p0_reg.x[COORD_W-1]}}, p0_reg.x};
                add_sub = 1'b1;
            end
            ST_MUL: begin
                add_a   = {2'b00, acc_reg[PROD_W-1:MAG_W]};
                add_b   = acc_reg[0] ? {2'b00, mcand_reg} : '0;
            end
            ST_DIV: begin
                add_a   = {1'b0, rem_reg, acc_reg[PROD_W-1]};
                add_b   = {2'b00, dvsr_reg};
                add_sub = 1'b1;
            end
            default: begin
                add_a   = '0;
            end
        endcase
        add_sum = add_a + (add_sub ? ~add_b : add_b) + ADD_W'(add_sub);
    end

    // ------------------------------------------------------------------
    // magnitudes and sign for the multiply and divide
    logic [COORD_W:0] dx_abs, dy_abs, den_abs;

    always_comb begin
        dx_abs  = dx_reg[COORD_W]  ? ((COORD_W + 1)'(0) - dx_reg)  : dx_reg;
        dy_abs  = dy_reg[COORD_W]  ? ((COORD_W + 1)'(0) - dy_reg)  : dy_reg;
        den_abs = den_reg[COORD_W] ? ((COORD_W + 1)'(0) - den_reg) : den_reg;
    end

    // ------------------------------------------------------------------
    // final add, saturation and result packing
    logic                     q_sat;
    logic signed [SW-1:0]     q_ext, y0_ext, sum_w, r_val;
    logic [COORD_W-1:0]       res_value;
    logic [IDX_W-1:0]         res_span;

    always_comb begin
        q_sat  = |acc_reg[PROD_W-1:QW];
        q_ext  = {2'b00, acc_reg[QW-1:0]};
        y0_ext = {{(SW - COORD_W){p0_reg.y[COORD_W-1]}}, p0_reg.y};
        sum_w  = neg_reg ? (y0_ext - q_ext) : (y0_ext + q_ext);
        if (q_sat) begin
            r_val = neg_reg ? LO_LIM : HI_LIM;
        end else if (sum_w > HI_LIM) begin
            r_val = HI_LIM;
        end else if (sum_w < LO_LIM) begin
            r_val = LO_LIM;
        end else begin
            r_val = sum_w;
        end
        if (is_load_reg) begin
            res_value = '0;
            res_span  = '0;
        end else begin
            res_value = r_val[COORD_W-1:0];
            res_span  = rep_reg ? span_ext[IDX_W-1:0] : start_reg;
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    always_comb begin
        state_next    = state_reg;
        span_next     = span_reg;
        last_next     = last_reg;
        cnt_next      = cnt_reg;
        x_next        = x_reg;
        start_next    = start_reg;
        rep_next      = rep_reg;
        is_load_next  = is_load_reg;
        p0_next       = p0_reg;
        p1_next       = p1_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        den_next      = den_reg;
        mcand_next    = mcand_reg;
        dvsr_next     = dvsr_reg;
        neg_next      = neg_reg;
        acc_next      = acc_reg;
        rem_next      = rem_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    is_load_next = (s_tuser == REQ_LOAD);
                    x_next       = in_ex;
                    start_next   = in_start;
                    rep_next     = in_report;
                    span_next    = span0_ext[SPAN_W-1:0];
                    last_next    = last_ext[SPAN_W-1:0];
                    state_next   = (s_tuser == REQ_LOAD) ? ST_DONE : ST_UP_RD;
                end
            end
            // walk up while x reaches the next point
            ST_UP_RD: begin
                state_next = (span_reg == last_reg) ? ST_DN_RD : ST_UP_CMP;
            end
            ST_UP_CMP: begin
                if (!add_sum[ADD_W-1]) begin
                    span_next  = span_reg + SPAN_W'(1);
                    state_next = ST_UP_RD;
                end else begin
                    state_next = ST_DN_RD;
                end
            end
            // walk down while x is below the current point
            ST_DN_RD: begin
                state_next = (span_reg == '0) ? ST_RD_P0 : ST_DN_CMP;
            end
            ST_DN_CMP: begin
                if (add_sum[ADD_W-1]) begin
                    span_next  = span_reg - SPAN_W'(1);
                    state_next = ST_DN_RD;
                end else begin
                    state_next = ST_RD_P0;
                end
            end
            // fetch both ends of the span
            ST_RD_P0: begin
                state_next = ST_RD_P1;
            end
            ST_RD_P1: begin
                p0_next    = rd_pt;
                state_next = ST_GET_P1;
            end
            ST_GET_P1: begin
                p1_next    = rd_pt;
                state_next = ST_DX;
            end
            ST_DX: begin
                dx_next    = add_sum[COORD_W:0];
                state_next = ST_DY;
            end
            ST_DY: begin
                dy_next    = add_sum[COORD_W:0];
                state_next = ST_DEN;
            end
            ST_DEN: begin
                den_next   = add_sum[COORD_W:0];
                state_next = ST_SETUP;
            end
            // zero-width span gives y0: quotient forced to zero
            ST_SETUP: begin
                mcand_next = dy_abs[MAG_W-1:0];
                dvsr_next  = den_abs[MAG_W-1:0];
                neg_next   = dx_reg[COORD_W] ^ dy_reg[COORD_W] ^ den_reg[COORD_W];
                rem_next   = '0;
                cnt_next   = '0;
                if (den_reg == '0) begin
                    acc_next   = '0;
                    state_next = ST_DONE;
                end else begin
                    acc_next   = {{(PROD_W - MAG_W){1'b0}}, dx_abs[MAG_W-1:0]};
                    state_next = ST_MUL;
                end
            end
            // shift-add multiply, one multiplier bit per cycle
            ST_MUL: begin
                acc_next = {add_sum[MAG_W:0], acc_reg[MAG_W-1:1]};
                cnt_next = cnt_reg + STEP_CNT_W'(1);
                if (cnt_reg == MUL_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            // restoring divide, one quotient bit per cycle
            ST_DIV: begin
                if (!add_sum[ADD_W-1]) begin
                    rem_next = add_sum[MAG_W-1:0];
                end else begin
                    rem_next = {rem_reg[MAG_W-2:0], acc_reg[PROD_W-1]};
                end
                acc_next = {acc_reg[PROD_W-2:0], !add_sum[ADD_W-1]};
                cnt_next = cnt_reg + STEP_CNT_W'(1);
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_DONE;
                end
            end
            // hand the result to the output register once it is free
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_TDATA_W'({res_span, res_value});
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_tvalid_reg   <= 1'b0;
            num_points_reg <= NUM_POINTS_RESET;
        end else begin
            state_reg      <= state_next;
            m_tvalid_reg   <= m_tvalid_next;
            num_points_reg <= num_points_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        span_reg    <= span_next;
        last_reg    <= last_next;
        cnt_reg     <= cnt_next;
        x_reg       <= x_next;
        start_reg   <= start_next;
        rep_reg     <= rep_next;
        is_load_reg <= is_load_next;
        p0_reg      <= p0_next;
        p1_reg      <= p1_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        den_reg     <= den_next;
        mcand_reg   <= mcand_next;
        dvsr_reg    <= dvsr_next;
        neg_reg     <= neg_next;
        acc_reg     <= acc_next;
        rem_reg     <= rem_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
